// ----- sv/ier_pkg.sv -----
`default_nettype none
package ier_pkg;

	// message store geometry: two banks so one message can fill while another replies
	localparam int MAX_MESSAGE_WORDS = 64;
	localparam int STORE_DEPTH       = 64;
	localparam int WIDX_W            = 6;
	localparam int WCNT_W            = WIDX_W + 1;
	localparam int NUM_BANKS         = 2;
	localparam int BANK_W            = 1;
	localparam int MEM_AW            = BANK_W + WIDX_W;

	// register port
	localparam int APB_AW    = 3;
	localparam int REG_IDX_W = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_IFACE_ADDR = REG_IDX_W'(0);

	// ICMP types
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
	localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;

	localparam logic [3:0] BEAT_BYTES = 4'd8;

	// store write port, front to back
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [63:0]       data;
	} store_wr_t;

	// one accepted echo request waiting for its reply
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [WCNT_W-1:0] nwords;
		logic [3:0]        last_bytes;
		logic [7:0]        code;
		logic [15:0]       cks;
		logic [31:0]       src;
	} reply_desc_t;

	// fold a wide sum back to 16 bits with end-around carry
	function automatic logic [15:0] oc_fold(input logic [18:0] t);
		logic [16:0] f;
		f = 17'(t[15:0]) + 17'(t[18:16]);
		return f[15:0] + 16'(f[16]);
	endfunction

endpackage
`default_nettype wire

// ----- sv/ier_if.sv -----
`default_nettype none
// request beats into the block
interface ier_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        last_word;
	logic [31:0] source_address;
	logic [31:0] destination_address;

	modport source (output valid, data_word, valid_bytes, last_word, source_address,
		destination_address, input ready);
	modport sink (input valid, data_word, valid_bytes, last_word, source_address,
		destination_address, output ready);
endinterface

// reply beats out of the block
interface ier_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] reply_word;
	logic [3:0]  reply_valid_bytes;
	logic        reply_last;
	logic [31:0] reply_source;
	logic [31:0] reply_destination;

	modport source (output valid, reply_word, reply_valid_bytes, reply_last, reply_source,
		reply_destination, input ready);
	modport sink (input valid, reply_word, reply_valid_bytes, reply_last, reply_source,
		reply_destination, output ready);
endinterface
`default_nettype wire

// ----- sv/ier_front.sv -----
`default_nettype none
module ier_front import ier_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	ier_in_if.sink      req,
	input  wire         q_full,
	output logic        q_push,
	output reply_desc_t q_desc,
	output store_wr_t   st_wr
);

	logic [WCNT_W-1:0] wc_q;
	logic [15:0]       run_sum_q;
	logic [15:0]       rep_sum_q;
	logic              ovf_q;
	logic              fin_q;
	logic [3:0]        fin_vb_q;
	logic [BANK_W-1:0] bank_q;
	logic [7:0]        type_q;
	logic [7:0]        code_q;
	logic [31:0]       src_q;

	logic        acc;
	logic [3:0]  vb;
	logic [63:0] mask;
	logic [63:0] wm;
	logic        first;
	logic        full_cnt;
	logic [15:0] run_nxt;
	logic [15:0] rep_nxt;
	logic [15:0] sum_code;
	logic        msg_ok;

	// no beat while a message finishes, and none while both banks are taken
	assign req.ready = !fin_q && !q_full;
	assign acc       = req.valid && req.ready;

	// effective byte count and masking of unused bytes
	always_comb begin
		if (!req.last_word || req.valid_bytes > BEAT_BYTES) begin
			vb = BEAT_BYTES;
		end else begin
			vb = req.valid_bytes;
		end
		for (int i = 0; i < 8; i++) begin
			mask[63-8*i -: 8] = (4'(i) < vb) ? 8'hFF : 8'h00;
		end
	end

	assign wm       = req.data_word & mask;
	assign first    = (wc_q == '0);
	assign full_cnt = (wc_q == WCNT_W'(MAX_MESSAGE_WORDS));

	// checksum sums; the reply sum skips type, code and checksum of word 0
	assign run_nxt = oc_fold(19'(run_sum_q) + 19'(wm[63:48]) + 19'(wm[47:32])
		+ 19'(wm[31:16]) + 19'(wm[15:0]));
	assign rep_nxt = oc_fold(19'(rep_sum_q)
		+ (first ? 19'd0 : (19'(wm[63:48]) + 19'(wm[47:32])))
		+ 19'(wm[31:16]) + 19'(wm[15:0]));

	// store write
	assign st_wr.en   = acc && !full_cnt;
	assign st_wr.addr = {bank_q, wc_q[WIDX_W-1:0]};
	assign st_wr.data = wm;

	// end of message checks and reply descriptor
	assign msg_ok = !ovf_q
		&& !(wc_q == WCNT_W'(1) && fin_vb_q < BEAT_BYTES)
		&& run_sum_q == 16'hFFFF
		&& type_q == ICMP_ECHO_REQUEST;
	assign sum_code = oc_fold(19'(rep_sum_q) + 19'(code_q));
	assign q_push   = fin_q && msg_ok;

	always_comb begin
		q_desc.bank       = bank_q;
		q_desc.nwords     = (fin_vb_q == '0) ? wc_q - WCNT_W'(1) : wc_q;
		q_desc.last_bytes = (fin_vb_q == '0) ? BEAT_BYTES : fin_vb_q;
		q_desc.code       = code_q;
		q_desc.cks        = ~sum_code;
		q_desc.src        = src_q;
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q      <= '0;
			run_sum_q <= '0;
			rep_sum_q <= '0;
			ovf_q     <= 1'b0;
			fin_q     <= 1'b0;
			fin_vb_q  <= '0;
			bank_q    <= '0;
		end else if (fin_q) begin
			wc_q      <= '0;
			run_sum_q <= '0;
			rep_sum_q <= '0;
			ovf_q     <= 1'b0;
			fin_q     <= 1'b0;
			if (msg_ok) begin
				bank_q <= bank_q + BANK_W'(1);
			end
		end else if (acc) begin
			if (full_cnt) begin
				ovf_q <= 1'b1;
			end else begin
				wc_q      <= wc_q + WCNT_W'(1);
				run_sum_q <= run_nxt;
				rep_sum_q <= rep_nxt;
			end
			if (req.last_word) begin
				fin_q    <= 1'b1;
				fin_vb_q <= vb;
			end
		end
	end

	// header fields taken from the first beat
	always_ff @(posedge clk) begin
		if (acc && first) begin
			src_q  <= req.source_address;
			type_q <= wm[63:56];
			code_q <= wm[55:48];
		end
	end

endmodule
`default_nettype wire

// ----- sv/ier_queue.sv -----
`default_nettype none
module ier_queue import ier_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	input  wire reply_desc_t din,
	input  wire         pop,
	output logic        head_valid,
	output reply_desc_t head,
	output logic        full
);

	reply_desc_t       ent_q [NUM_BANKS];
	logic [BANK_W-1:0] wp_q;
	logic [BANK_W-1:0] rp_q;
	logic [BANK_W:0]   cnt_q;

	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == (BANK_W+1)'(NUM_BANKS));
	assign head       = ent_q[rp_q];

	// pointers and fill level; an entry stays until its reply is fully sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + BANK_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + BANK_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (BANK_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (BANK_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

endmodule
`default_nettype wire

// ----- sv/ier_back.sv -----
`default_nettype none
module ier_back import ier_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire store_wr_t st_wr,
	input  wire         q_valid,
	input  wire reply_desc_t q_head,
	output logic        q_pop,
	input  wire [31:0]  iface_addr,
	ier_out_if.source   rsp
);

	typedef enum logic {ST_IDLE, ST_SHOW} state_t;

	state_t            state_q;
	logic [WIDX_W-1:0] idx_q;
	logic [63:0]       mem [NUM_BANKS*STORE_DEPTH];
	logic [63:0]       rdata_q;

	logic              rd_en;
	logic [MEM_AW-1:0] rd_addr;
	logic              take;
	logic              at_last;

	assign take    = rsp.valid && rsp.ready;
	assign at_last = (WCNT_W'(idx_q) == q_head.nwords - WCNT_W'(1));

	// read word 0 when a request is queued, else the next word as the current beat leaves
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {q_head.bank, idx_q + WIDX_W'(1)};
		q_pop   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					rd_en   = 1'b1;
					rd_addr = {q_head.bank, WIDX_W'(0)};
				end
			end
			ST_SHOW: begin
				if (take) begin
					if (at_last) begin
						q_pop = 1'b1;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SHOW;
						idx_q   <= '0;
					end
				end
				ST_SHOW: begin
					if (take) begin
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + WIDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// message store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (st_wr.en) begin
			mem[st_wr.addr] <= st_wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// reply beat; word 0 gets the reply type and new checksum
	assign rsp.valid = (state_q == ST_SHOW);
	assign rsp.reply_word = (idx_q == '0)
		? {ICMP_ECHO_REPLY, q_head.code, q_head.cks, rdata_q[31:0]}
		: rdata_q;
	assign rsp.reply_valid_bytes = at_last ? q_head.last_bytes : BEAT_BYTES;
	assign rsp.reply_last        = at_last;
	assign rsp.reply_source      = iface_addr;
	assign rsp.reply_destination = q_head.src;

endmodule
`default_nettype wire

// ----- sv/icmp_echo_responder_unit.sv -----
// ICMP echo responder.
// req carries an ICMP message as 64-bit big-endian beats (first byte in bits 63:56)
// with the sender and destination addresses; valid_bytes counts on the last beat only.
// rsp carries the echo reply beats with the interface address as source and the
// request's sender as destination. Bad checksum, short, oversize (over 64 beats)
// and non-request messages are dropped silently.
// The APB port holds the interface address at byte address 0.
// Throughput: one request beat per cycle while the queue has room, none while a
// message finishes; one reply beat per cycle while rsp is ready. The back end
// returns to idle between replies; from idle, the first reply beat follows the last
// accepted request beat through the finishing state, the queue and the store read.
// The two-bank store lets one message be received while the previous reply is sent.
// When rsp stalls the current beat holds; req takes at most one more message that
// passes the checks, then drops ready until the pending reply has gone out.
// Reset clears all control state and the interface address; the store holds no
// valid data until a message is written into it.
`default_nettype none
module icmp_echo_responder_unit import ier_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	ier_in_if.sink             req,
	ier_out_if.source          rsp,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [APB_AW-1:0]   paddr,
	input  wire [31:0]         pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic        [31:0] iface_q;
	logic               cfg_wr;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_valid;
	reply_desc_t        q_desc;
	reply_desc_t        q_head;
	store_wr_t          st_wr;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[APB_AW-1:2] == REG_IFACE_ADDR) ? iface_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iface_q <= '0;
		end else if (cfg_wr && paddr[APB_AW-1:2] == REG_IFACE_ADDR) begin
			iface_q <= pwdata;
		end
	end

	ier_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_desc (q_desc),
		.st_wr  (st_wr)
	);

	ier_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.din        (q_desc),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head),
		.full       (q_full)
	);

	ier_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.st_wr      (st_wr),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.iface_addr (iface_q),
		.rsp        (rsp)
	);

	// a reply beat always belongs to a queued request
	ap_beat_has_desc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> q_valid)
		else $error("reply beat without a queued request");

	// the front never finishes a message into a full queue
	ap_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("request queued while both banks are busy");

	// a request leaves the queue only with its last reply beat
	ap_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (rsp.valid && rsp.ready && rsp.reply_last))
		else $error("request retired before its last reply beat");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import ier_pkg::*;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  vb;
		logic        last;
		logic [31:0] src;
		logic [31:0] dst;
	} req_beat_t;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
		logic [31:0] src;
		logic [31:0] dst;
	} echo_beat_t;

	typedef enum int {TAIL_NONE, TAIL_EMPTY, TAIL_WIDE} tail_t;
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ier_in_if  req();
	ier_out_if rsp();

	icmp_echo_responder_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// stimulus and expected reply beats
	req_beat_t  request_beats[$];
	echo_beat_t echo_beats_due[$];
	logic [7:0] msg_bytes[$];

	int beats_queued, beats_taken, msg_count, echo_beats_seen, echo_count, fail_count;
	int in_gap, out_gap;
	logic quiet;
	req_beat_t drv_beat;

	// shadow of the block
	logic [63:0] msg_image[MAX_MESSAGE_WORDS];
	int          img_words;
	logic [15:0] chk_sum, rpl_sum;
	logic        too_long;
	logic [31:0] sender;
	logic [31:0] iface_model;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'b0, t[16]};
	endfunction

	function automatic logic [63:0] byte_mask(input int n);
		if (n >= 8)
			return '1;
		return ~({64{1'b1}} >> (8 * n));
	endfunction

	// fold one accepted request beat in; on the last beat, queue the echo reply beats
	task automatic predict_beat(input req_beat_t b);
		logic [63:0] word, w;
		logic [15:0] h, cks;
		logic [7:0]  code;
		int vb, total, nwords, n;
		echo_beat_t r;
		vb = b.last ? int'(b.vb) : 8;
		if (vb > 8)
			vb = 8;
		word = b.data & byte_mask(vb);
		if (img_words == 0 && !too_long)
			sender = b.src;
		if (img_words >= MAX_MESSAGE_WORDS) begin
			too_long = 1'b1;
		end else begin
			msg_image[img_words] = word;
			for (int i = 0; i < 4; i++) begin
				h = word[63 - 16 * i -: 16];
				chk_sum = ones_add(chk_sum, h);
				// reply checksum skips type, code and the old checksum
				if (img_words != 0 || i >= 2)
					rpl_sum = ones_add(rpl_sum, h);
			end
			img_words++;
		end
		if (!b.last)
			return;
		total = (img_words - 1) * 8 + vb;
		if (!too_long && img_words != 0 && total >= 8 && chk_sum == 16'hFFFF &&
			msg_image[0][63:56] == ICMP_ECHO_REQUEST) begin
			code = msg_image[0][55:48];
			cks = ~ones_add(rpl_sum, {8'h00, code});
			nwords = (total + 7) / 8;
			for (int i = 0; i < nwords; i++) begin
				w = msg_image[i];
				n = (i + 1 == nwords) ? total - i * 8 : 8;
				if (i == 0)
					w = {ICMP_ECHO_REPLY, code, cks, w[31:0]};
				r.word = w & byte_mask(n);
				r.nbytes = 4'(n);
				r.last = (i + 1 == nwords);
				r.src = iface_model;
				r.dst = sender;
				echo_beats_due.push_back(r);
			end
		end
		img_words = 0;
		chk_sum = '0;
		rpl_sum = '0;
		too_long = 1'b0;
	endtask

	// message bytes with a correct checksum where the header holds one
	task automatic build_msg(input logic [7:0] kind, input logic [7:0] code, input int len,
		input fill_t fill);
		logic [15:0] sum;
		msg_bytes.delete();
		for (int i = 0; i < len; i++)
			msg_bytes.push_back(fill == FILL_ZERO ? 8'h00 :
				fill == FILL_ONES ? 8'hFF : 8'($urandom));
		msg_bytes[0] = kind;
		if (len > 1)
			msg_bytes[1] = code;
		if (len >= 4) begin
			msg_bytes[2] = 8'h00;
			msg_bytes[3] = 8'h00;
			sum = '0;
			for (int i = 0; i < len; i += 2)
				sum = ones_add(sum, {msg_bytes[i], (i + 1 < len) ? msg_bytes[i + 1] : 8'h00});
			msg_bytes[2] = ~sum[15:8];
			msg_bytes[3] = ~sum[7:0];
		end
	endtask

	task automatic corrupt_msg();
		int k;
		k = $urandom_range(0, msg_bytes.size() - 1);
		msg_bytes[k] = msg_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
	endtask

	function automatic logic [31:0] pick_dst();
		case ($urandom_range(0, 3))
			0: begin
				return iface_model;
			end
			1: begin
				return 32'hFFFF_FFFF;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// chop msg_bytes into request beats; garbage past the valid bytes
	task automatic queue_msg(input tail_t tail, input logic [31:0] src);
		req_beat_t b;
		int nb, nw, rem;
		nb = msg_bytes.size();
		nw = (nb + 7) / 8;
		for (int w = 0; w < nw; w++) begin
			b.data = {$urandom, $urandom};
			for (int k = 0; k < 8; k++)
				if (w * 8 + k < nb)
					b.data[63 - 8 * k -: 8] = msg_bytes[w * 8 + k];
			rem = nb - 8 * w;
			b.last = (w == nw - 1) && tail != TAIL_EMPTY;
			if (b.last)
				b.vb = (rem >= 8) ? 4'd8 : 4'(rem);
			else
				b.vb = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : BEAT_BYTES;
			if (b.last && tail == TAIL_WIDE && rem >= 8)
				b.vb = 4'($urandom_range(9, 15));
			b.src = (w == 0 || $urandom_range(0, 4) != 0) ? src : $urandom;
			b.dst = pick_dst();
			request_beats.push_back(b);
			beats_queued++;
		end
		if (tail == TAIL_EMPTY) begin
			b.data = {$urandom, $urandom};
			b.vb = 4'd0;
			b.last = 1'b1;
			b.src = $urandom;
			b.dst = pick_dst();
			request_beats.push_back(b);
			beats_queued++;
		end
		msg_count++;
	endtask

	function automatic logic [31:0] pick_src();
		case ($urandom_range(0, 9))
			0: begin
				return 32'h0;
			end
			1: begin
				return 32'hFFFF_FFFF;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// one random message: mostly good echo requests, the rest broken or ignored
	task automatic random_msg();
		int r, len;
		logic [7:0] kind;
		tail_t tail;
		r = $urandom_range(0, 99);
		len = $urandom_range(8, 48);
		tail = TAIL_NONE;
		if ($urandom_range(0, 9) == 0)
			tail = TAIL_WIDE;
		else if ($urandom_range(0, 9) == 0)
			tail = TAIL_EMPTY;
		if (r < 70) begin
			build_msg(ICMP_ECHO_REQUEST, 8'($urandom), len, FILL_RANDOM);
		end else if (r < 78) begin
			kind = 8'($urandom);
			if (kind == ICMP_ECHO_REQUEST)
				kind = 8'd13;
			build_msg(kind, 8'($urandom), len, FILL_RANDOM);
		end else if (r < 86) begin
			build_msg(ICMP_ECHO_REQUEST, 8'($urandom), len, FILL_RANDOM);
			corrupt_msg();
		end else if (r < 92) begin
			build_msg(ICMP_ECHO_REQUEST, 8'($urandom), $urandom_range(1, 7), FILL_RANDOM);
		end else if (r < 95) begin
			build_msg(ICMP_ECHO_REQUEST, 8'($urandom), $urandom_range(400, 8 * MAX_MESSAGE_WORDS),
				FILL_RANDOM);
		end else if (r < 97) begin
			build_msg(ICMP_ECHO_REQUEST, 8'($urandom),
				$urandom_range(8 * MAX_MESSAGE_WORDS + 1, 8 * MAX_MESSAGE_WORDS + 24), FILL_RANDOM);
		end else begin
			build_msg(ICMP_ECHO_REQUEST, 8'($urandom), $urandom_range(49, 120), FILL_RANDOM);
		end
		queue_msg(tail, pick_src());
	endtask

	task automatic random_phase(input int nbeats);
		int start;
		start = beats_queued;
		while (beats_queued - start < nbeats)
			random_msg();
	endtask

	// register write, then read back
	task automatic write_iface(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({REG_IFACE_ADDR, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		iface_model = value;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("interface_address: expected %h, got %h", value, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every beat is in and every reply is out, then let any dropped messages settle
	task automatic drain();
		do @(negedge clk);
		while (request_beats.size() != 0 || beats_taken != beats_queued ||
			echo_beats_due.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data_word <= '0;
			req.valid_bytes <= '0;
			req.last_word <= 1'b0;
			req.source_address <= '0;
			req.destination_address <= '0;
			in_gap <= 0;
		end else if (!req.valid || req.ready) begin
			if (in_gap > 0) begin
				req.valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (request_beats.size() > 0) begin
				drv_beat = request_beats.pop_front();
				req.valid <= 1'b1;
				req.data_word <= drv_beat.data;
				req.valid_bytes <= drv_beat.vb;
				req.last_word <= drv_beat.last;
				req.source_address <= drv_beat.src;
				req.destination_address <= drv_beat.dst;
				if (!quiet && $urandom_range(0, 5) == 0)
					in_gap <= $urandom_range(1, 10);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// request monitor feeds the shadow
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			predict_beat('{req.data_word, req.valid_bytes, req.last_word,
				req.source_address, req.destination_address});
			beats_taken++;
		end
	end

	// reply backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			out_gap <= 0;
		end else if (out_gap > 0) begin
			rsp.ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			rsp.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0)
				out_gap <= $urandom_range(1, 10);
		end
	end

	// reply checker
	always @(posedge clk) begin
		echo_beat_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			echo_beats_seen++;
			if (echo_beats_due.size() == 0) begin
				$error("reply beat with none expected: word %h", rsp.reply_word);
				fail_count++;
			end else begin
				e = echo_beats_due.pop_front();
				if (rsp.reply_last === 1'b1)
					echo_count++;
				if (rsp.reply_word !== e.word) begin
					$error("reply_word: expected %h, got %h", e.word, rsp.reply_word);
					fail_count++;
				end
				if (rsp.reply_valid_bytes !== e.nbytes) begin
					$error("reply_valid_bytes: expected %0d, got %0d", e.nbytes,
						rsp.reply_valid_bytes);
					fail_count++;
				end
				if (rsp.reply_last !== e.last) begin
					$error("reply_last: expected %0d, got %0d", e.last, rsp.reply_last);
					fail_count++;
				end
				if (rsp.reply_source !== e.src) begin
					$error("reply_source: expected %h, got %h", e.src, rsp.reply_source);
					fail_count++;
				end
				if (rsp.reply_destination !== e.dst) begin
					$error("reply_destination: expected %h, got %h", e.dst,
						rsp.reply_destination);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		beats_queued = 0;
		beats_taken = 0;
		msg_count = 0;
		echo_beats_seen = 0;
		echo_count = 0;
		fail_count = 0;
		img_words = 0;
		chk_sum = '0;
		rpl_sum = '0;
		too_long = 1'b0;
		sender = '0;
		iface_model = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, odd length, wide and empty last beats, drops
		write_iface(32'hFFFF_FFFF);
		build_msg(ICMP_ECHO_REQUEST, 8'h00, 8, FILL_ZERO);
		queue_msg(TAIL_NONE, 32'h0);
		build_msg(ICMP_ECHO_REQUEST, 8'hFF, 9, FILL_ONES);
		queue_msg(TAIL_NONE, 32'hFFFF_FFFF);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 15, FILL_RANDOM);
		queue_msg(TAIL_NONE, $urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 16, FILL_RANDOM);
		queue_msg(TAIL_WIDE, $urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 16, FILL_RANDOM);
		queue_msg(TAIL_EMPTY, $urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 7, FILL_RANDOM);
		queue_msg(TAIL_NONE, $urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 1, FILL_RANDOM);
		queue_msg(TAIL_NONE, $urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 12, FILL_RANDOM);
		corrupt_msg();
		queue_msg(TAIL_NONE, $urandom);
		build_msg(ICMP_ECHO_REPLY, 8'h00, 8, FILL_RANDOM);
		queue_msg(TAIL_NONE, $urandom);
		build_msg(8'd13, 8'h00, 12, FILL_RANDOM);
		queue_msg(TAIL_NONE, $urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'h00, 24, FILL_ONES);
		queue_msg(TAIL_NONE, $urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'h00, 24, FILL_ZERO);
		queue_msg(TAIL_NONE, $urandom);
		drain();

		// random, then one full-size message
		write_iface(32'h0);
		random_phase(6);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 8 * MAX_MESSAGE_WORDS, FILL_RANDOM);
		queue_msg(TAIL_NONE, pick_src());
		drain();

		// one message over the limit, then random
		write_iface($urandom);
		build_msg(ICMP_ECHO_REQUEST, 8'($urandom), 8 * MAX_MESSAGE_WORDS + 5, FILL_RANDOM);
		queue_msg(TAIL_NONE, pick_src());
		random_phase(6);
		drain();

		// random, back to back on both sides
		write_iface($urandom);
		quiet = 1'b1;
		random_phase(12);
		drain();

		$display("%0d request beats in %0d messages over 4 interface addresses,",
			beats_queued, msg_count);
		$display("%0d reply beats checked in %0d echo replies", echo_beats_seen, echo_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
sv/ier_pkg.sv
sv/ier_if.sv
sv/ier_front.sv
sv/ier_queue.sv
sv/ier_back.sv
sv/icmp_echo_responder_unit.sv
tb/tb_top.sv
